@@ rtl/top_n_beacon_selector_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the beacon selector
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOP_N_BEACON_SELECTOR_TOP_MACROS_SVH
`define TOP_N_BEACON_SELECTOR_TOP_MACROS_SVH

// same-cycle implication
`define TNBS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TNBS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tnbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Beacon selector package
// Sizes, field types, register indexes and item codes.
// ----------------------------------------------------------------------------
package tnbs_pkg;

	// storage sizes
	localparam int MAX_KEEP    = 16;
	localparam int TABLE_DEPTH = 64;

	// rank list index and count widths
	localparam int RK_AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int RK_CW = $clog2(MAX_KEEP + 1);

	// reference table index and fill widths
	localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int ID_W       = 32;
	localparam int DBM_W      = 8;
	localparam int KEY_W      = 9;
	localparam int KEEP_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic [ID_W-1:0]         beacon_id_t;
	typedef logic signed [DBM_W-1:0] dbm_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

	// reference table entry
	typedef struct packed {
		beacon_id_t id;
		dbm_t       power;
	} tbl_entry_t;

	localparam int TBL_W = $bits(tbl_entry_t);

	// configuration register indexes
	localparam cfg_idx_t REG_KEEP_COUNT    = 2'd0;
	localparam cfg_idx_t REG_CUTOFF_DBM    = 2'd1;
	localparam cfg_idx_t REG_ADJUST_ENABLE = 2'd2;

	// item kinds
	localparam logic FUNC_BEACON = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	// register reset values
	localparam logic [KEEP_W-1:0] KEEP_RST   = 5'd10;
	localparam dbm_t              CUTOFF_RST = -8'sd100;

endpackage

@@ rtl/tnbs_if.sv @@
// ----------------------------------------------------------------------------
// Beacon selector channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------

// input item channel
interface tnbs_item_if;
	import tnbs_pkg::*;

	logic       valid;
	logic       ready;
	logic       func;
	beacon_id_t beacon_id;
	dbm_t       signal_dbm;
	dbm_t       ref_power_dbm;
	logic       end_of_scan;

	modport source (output valid, func, beacon_id, signal_dbm, ref_power_dbm, end_of_scan,
		input ready);
	modport sink (input valid, func, beacon_id, signal_dbm, ref_power_dbm, end_of_scan,
		output ready);
endinterface

// result item channel
interface tnbs_result_if;
	import tnbs_pkg::*;

	logic       valid;
	logic       ready;
	beacon_id_t out_id;
	dbm_t       out_dbm;
	logic       valid_res;
	logic       last;

	modport source (output valid, out_id, out_dbm, valid_res, last, input ready);
	modport sink (input valid, out_id, out_dbm, valid_res, last, output ready);
endinterface

@@ rtl/tnbs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tnbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/top_n_beacon_selector_top.sv @@
// ----------------------------------------------------------------------------
// Top-N beacon selector
// Keeps the strongest beacons of a scan and emits them strongest first.
// ----------------------------------------------------------------------------
// Items enter on the item channel (valid/ready). A load item (func 1) writes
// an id and reference power into a 64-entry table; a known id is updated, a
// new id is dropped when the table is full. A beacon item (func 0) is ranked
// in a list of up to keep_count entries, at most 16; with adjust_enable set
// and the id in the table, the rank key is RSSI minus the table power.
// On a beacon with end_of_scan set, the kept beacons whose RSSI is above
// cutoff_dbm leave on the result channel, strongest first, the final one with
// last set; if none qualify, one result with valid_res 0 and last 1 is sent.
// Steps per item: a table walk reads the filled entries in turn until the id
// matches (states TRD then TCMP), driven by the table RAM's registered read;
// it runs for every load and, with adjusting on, for every beacon. Ranking
// steps through the list entries, stopping at the insert slot. End of scan adds
// two passes over the list, the emit pass also waiting out any output stalls.
// Item ready is high only while the sequencer is idle. A stalled receiver
// holds the output register and the emit pass waits for it.
// Reset empties the table and the rank list at once (fill and count go to
// zero, no clearing pass) and loads the register defaults.
module top_n_beacon_selector_top (
	input  logic                             clk,
	input  logic                             arst_n,
	tnbs_item_if.sink                        item,
	tnbs_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [tnbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tnbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import tnbs_pkg::*;

`include "top_n_beacon_selector_top_macros.svh"

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TRD   = 3'd1;
	localparam logic [2:0] S_TCMP  = 3'd2;
	localparam logic [2:0] S_RSCAN = 3'd3;
	localparam logic [2:0] S_LAST  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;

	// configuration registers
	logic [KEEP_W-1:0] keep_q;
	dbm_t              cutoff_q;
	logic              adjust_q;

	// captured item
	logic       func_q;
	beacon_id_t id_q;
	dbm_t       rssi_q;
	dbm_t       pwr_q;
	logic       eos_q;
	key_t       key_q;

	// rank list
	beacon_id_t        rank_ids_q  [MAX_KEEP];
	dbm_t              rank_rssi_q [MAX_KEEP];
	key_t              rank_keys_q [MAX_KEEP];
	logic [RK_CW-1:0]  rank_count_q;
	logic [RK_CW-1:0]  ptr_q;
	logic [RK_CW-1:0]  last_idx_q;
	logic              any_q;

	// reference table control
	logic [TBL_CW-1:0] fill_q;
	logic [TBL_CW-1:0] tptr_q;

	// output register
	logic       out_valid_q;
	beacon_id_t out_id_q;
	dbm_t       out_dbm_q;
	logic       out_vres_q;
	logic       out_last_q;

	// combinational
	logic [RK_CW-1:0]  lim;
	logic [RK_CW-1:0]  cnt;
	logic [RK_CW-1:0]  cnt_new;
	logic [RK_AW-1:0]  ptr_idx;
	logic              in_range;
	key_t              cur_key;
	logic              survivor;
	logic              ins_en;
	logic              slot_free;
	logic              emit_take;
	logic              none_take;
	logic              load_out;
	logic              tbl_hit_range;
	logic              tbl_room;
	logic              tbl_match;
	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_waddr;
	tbl_entry_t        tbl_wdata;
	logic [TBL_W-1:0]  tbl_rdata;
	tbl_entry_t        tbl_rd;
	key_t              adj_key;

	// reference table memory
	tnbs_ram #(
		.WIDTH (TBL_W),
		.DEPTH (TABLE_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tptr_q[TBL_AW-1:0]),
		.rdata (tbl_rdata)
	);

	// rank list limits and the shared compare
	always_comb begin
		lim      = (32'(keep_q) > 32'(MAX_KEEP)) ? RK_CW'(MAX_KEEP) : RK_CW'(keep_q);
		cnt      = (rank_count_q < lim) ? rank_count_q : lim;
		cnt_new  = (cnt < lim) ? cnt + 1'b1 : cnt;
		ptr_idx  = ptr_q[RK_AW-1:0];
		in_range = (ptr_q < cnt);
		cur_key  = rank_keys_q[ptr_idx];
		survivor = in_range && (rank_rssi_q[ptr_idx] > cutoff_q);
		ins_en   = (state_q == S_RSCAN) && !(in_range && (cur_key >= key_q)) && (ptr_q < lim);
	end

	// table walk
	always_comb begin
		tbl_rd        = tbl_entry_t'(tbl_rdata);
		tbl_hit_range = (tptr_q < fill_q);
		tbl_room      = (fill_q < TBL_CW'(TABLE_DEPTH));
		tbl_match     = (tbl_rd.id == id_q);
		adj_key       = {rssi_q[DBM_W-1], rssi_q} - {tbl_rd.power[DBM_W-1], tbl_rd.power};
		tbl_wdata     = '{id: id_q, power: pwr_q};
		tbl_we        = 1'b0;
		tbl_waddr     = tptr_q[TBL_AW-1:0];
		if (func_q == FUNC_LOAD) begin
			if ((state_q == S_TRD) && !tbl_hit_range && tbl_room) begin
				tbl_we    = 1'b1;
				tbl_waddr = fill_q[TBL_AW-1:0];
			end else if ((state_q == S_TCMP) && tbl_match) begin
				tbl_we = 1'b1;
			end
		end
	end

	// output slot
	always_comb begin
		slot_free = !out_valid_q || result.ready;
		emit_take = (state_q == S_EMIT) && survivor && slot_free;
		none_take = (state_q == S_EMIT) && !in_range && !any_q && slot_free;
		load_out  = emit_take || none_take;
	end

	assign item.ready       = (state_q == S_IDLE);
	assign result.valid     = out_valid_q;
	assign result.out_id    = out_id_q;
	assign result.out_dbm   = out_dbm_q;
	assign result.valid_res = out_vres_q;
	assign result.last      = out_last_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q   <= KEEP_RST;
			cutoff_q <= CUTOFF_RST;
			adjust_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEEP_COUNT:    keep_q   <= cfg_wdata[KEEP_W-1:0];
				REG_CUTOFF_DBM:    cutoff_q <= dbm_t'(cfg_wdata);
				REG_ADJUST_ENABLE: adjust_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ptr_q        <= '0;
			tptr_q       <= '0;
			rank_count_q <= '0;
			fill_q       <= '0;
			any_q        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						ptr_q  <= '0;
						tptr_q <= '0;
						if ((item.func == FUNC_LOAD) || adjust_q) begin
							state_q <= S_TRD;
						end else begin
							state_q <= S_RSCAN;
						end
					end
				end
				S_TRD: begin
					if (tbl_hit_range) begin
						state_q <= S_TCMP;
					end else if (func_q == FUNC_LOAD) begin
						if (tbl_room) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RSCAN;
					end
				end
				S_TCMP: begin
					if (tbl_match) begin
						state_q <= (func_q == FUNC_LOAD) ? S_IDLE : S_RSCAN;
					end else begin
						tptr_q  <= tptr_q + 1'b1;
						state_q <= S_TRD;
					end
				end
				S_RSCAN: begin
					if (in_range && (cur_key >= key_q)) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						if (ins_en) begin
							rank_count_q <= cnt_new;
						end
						ptr_q   <= '0;
						any_q   <= 1'b0;
						state_q <= eos_q ? S_LAST : S_IDLE;
					end
				end
				S_LAST: begin
					if (in_range) begin
						if (survivor) begin
							any_q <= 1'b1;
						end
						ptr_q <= ptr_q + 1'b1;
					end else begin
						ptr_q   <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (in_range) begin
						if (!survivor || slot_free) begin
							ptr_q <= ptr_q + 1'b1;
						end
					end else if (any_q || slot_free) begin
						rank_count_q <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// captured item and key
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item.valid) begin
			func_q <= item.func;
			id_q   <= item.beacon_id;
			rssi_q <= item.signal_dbm;
			pwr_q  <= item.ref_power_dbm;
			eos_q  <= item.end_of_scan;
			key_q  <= {item.signal_dbm[DBM_W-1], item.signal_dbm};
		end else if ((state_q == S_TCMP) && tbl_match) begin
			key_q <= adj_key;
		end
		if ((state_q == S_LAST) && survivor) begin
			last_idx_q <= ptr_q;
		end
	end

	// rank list insert: shift the tail down one place, write at the found slot
	always_ff @(posedge clk) begin
		if (ins_en) begin
			for (int i = 1; i < MAX_KEEP; i++) begin
				if ((RK_CW'(i) > ptr_q) && (RK_CW'(i) < cnt_new)) begin
					rank_ids_q[i]  <= rank_ids_q[i-1];
					rank_rssi_q[i] <= rank_rssi_q[i-1];
					rank_keys_q[i] <= rank_keys_q[i-1];
				end
			end
			for (int i = 0; i < MAX_KEEP; i++) begin
				if (RK_CW'(i) == ptr_q) begin
					rank_ids_q[i]  <= id_q;
					rank_rssi_q[i] <= rssi_q;
					rank_keys_q[i] <= key_q;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_take) begin
			out_id_q   <= rank_ids_q[ptr_idx];
			out_dbm_q  <= rank_rssi_q[ptr_idx];
			out_vres_q <= 1'b1;
			out_last_q <= (ptr_q == last_idx_q);
		end else if (none_take) begin
			out_id_q   <= '0;
			out_dbm_q  <= '0;
			out_vres_q <= 1'b0;
			out_last_q <= 1'b1;
		end
	end

	// checks
	`TNBS_ASSERT(a_rank_bound, 1'b1, rank_count_q <= RK_CW'(MAX_KEEP), "rank count over limit")
	`TNBS_ASSERT(a_fill_bound, 1'b1, fill_q <= TBL_CW'(TABLE_DEPTH), "table fill over depth")
	`TNBS_ASSERT(a_empty_last, result.valid && !result.valid_res, result.last, "empty result not last")
	`TNBS_ASSERT(a_scan_clear, (state_q == S_IDLE) && ($past(state_q) == S_EMIT), rank_count_q == '0, "scan not cleared")
	`TNBS_ASSERT_NXT(a_load_done, (state_q == S_TRD) && !tbl_hit_range && (func_q == FUNC_LOAD), state_q == S_IDLE, "load walk did not finish")

endmodule

@@ tb/top_n_beacon_selector_top_tb.sv @@
// ----------------------------------------------------------------------------
// Top-N beacon selector testbench
// Sends table loads and beacon scans under random valid/ready gaps and checks
// every result transfer against a predictor that keeps its own copy of the
// rank list, the reference table and the registers.
// ----------------------------------------------------------------------------
module top_n_beacon_selector_top_tb;
	import tnbs_pkg::*;

	localparam int RAND_ITEMS     = 100;
	localparam int FILL_LOADS     = 66;
	localparam int SETTLE_CYCLES  = 300;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int WATCHDOG_LIMIT = 5000;

	localparam dbm_t DBM_MIN = dbm_t'(8'h80);
	localparam dbm_t DBM_MAX = dbm_t'(8'h7F);

	localparam beacon_id_t ID_A = 32'h4C00_0101;
	localparam beacon_id_t ID_B = 32'h4C00_0102;
	localparam beacon_id_t ID_C = 32'h0E11_7A03;
	localparam beacon_id_t ID_D = 32'h0E11_7A04;
	localparam beacon_id_t ID_E = 32'h9B3D_0005;
	localparam beacon_id_t ID_F = 32'h2200_1006;
	localparam beacon_id_t ID_G = 32'h2200_1007;
	localparam beacon_id_t ID_H = 32'h2200_1008;
	localparam beacon_id_t ID_I = 32'h2200_1009;
	localparam beacon_id_t ID_J = 32'h7FFF_000A;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic       func;
		beacon_id_t id;
		dbm_t       rssi;
		dbm_t       ref_pwr;
		logic       eos;
	} item_t;

	typedef struct packed {
		beacon_id_t id;
		dbm_t       dbm;
		logic       vres;
		logic       last;
	} res_t;

	typedef struct packed {
		row_kind_t         kind;
		item_t             it;
		logic              typed;
		res_t              want;
		logic [KEEP_W-1:0] keep;
		dbm_t              cutoff;
		logic              adj;
	} row_t;

	localparam res_t NO_SURVIVOR = '{id: '0, dbm: '0, vres: 1'b0, last: 1'b1};

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tnbs_item_if   in_ch ();
	tnbs_result_if out_ch ();

	top_n_beacon_selector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (in_ch),
		.result    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state: rank list, reference table, registers
	beacon_id_t        rk_id [MAX_KEEP];
	dbm_t              rk_rssi [MAX_KEEP];
	key_t              rk_key [MAX_KEEP];
	int                rk_n = 0;
	beacon_id_t        ref_id [TABLE_DEPTH];
	dbm_t              ref_pwr [TABLE_DEPTH];
	int                ref_fill = 0;
	logic [KEEP_W-1:0] m_keep = KEEP_RST;
	dbm_t              m_cutoff = CUTOFF_RST;
	logic              m_adj = 1'b0;

	res_t       pending_results [$];
	beacon_id_t id_pool [$];
	logic       tx_calm;
	int         mismatches = 0;
	int         results_seen = 0;
	int         n_loads = 0;
	int         n_beacons = 0;
	int         n_scans = 0;
	int         holdoffs = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// table position of an id, -1 when absent
	function automatic int ref_index(beacon_id_t id);
		for (int i = 0; i < ref_fill; i++)
			if (ref_id[i] == id)
				return i;
		return -1;
	endfunction

	// applies one item to the predictor and returns the results it releases
	function automatic void rank_and_emit(input item_t it, output res_t res[$]);
		int   idx;
		int   lim;
		int   n;
		int   pos;
		key_t key;
		res_t r;
		res = {};
		if (it.func == FUNC_LOAD) begin
			idx = ref_index(it.id);
			if (idx >= 0) begin
				ref_pwr[idx] = it.ref_pwr;
			end else if (ref_fill < TABLE_DEPTH) begin
				ref_id[ref_fill]  = it.id;
				ref_pwr[ref_fill] = it.ref_pwr;
				ref_fill++;
			end
			return;
		end

		key = it.rssi;
		if (m_adj) begin
			idx = ref_index(it.id);
			if (idx >= 0)
				key = it.rssi - ref_pwr[idx];
		end

		// insert below every entry with an equal or higher key
		lim = (int'(m_keep) > MAX_KEEP) ? MAX_KEEP : int'(m_keep);
		n   = (rk_n < lim) ? rk_n : lim;
		pos = 0;
		while (pos < n && rk_key[pos] >= key)
			pos++;
		if (pos < lim) begin
			if (n < lim)
				n++;
			for (int i = n - 1; i > pos; i--) begin
				rk_id[i]   = rk_id[i-1];
				rk_rssi[i] = rk_rssi[i-1];
				rk_key[i]  = rk_key[i-1];
			end
			rk_id[pos]   = it.id;
			rk_rssi[pos] = it.rssi;
			rk_key[pos]  = key;
			rk_n         = n;
		end
		if (!it.eos)
			return;

		// end of scan: survivors strongest first, else one invalid result
		n = (rk_n < lim) ? rk_n : lim;
		for (int i = 0; i < n; i++) begin
			if (rk_rssi[i] > m_cutoff) begin
				r   = '{id: rk_id[i], dbm: rk_rssi[i], vres: 1'b1, last: 1'b0};
				res = {res, r};
			end
		end
		if (res.size() == 0)
			res = {res, NO_SURVIVOR};
		else
			res[res.size()-1].last = 1'b1;
		rk_n = 0;
	endfunction

	function automatic row_t beacon_row(beacon_id_t id, dbm_t rssi, logic eos);
		row_t r = '0;
		r.kind = ROW_ITEM;
		r.it   = '{func: FUNC_BEACON, id: id, rssi: rssi, ref_pwr: '0, eos: eos};
		return r;
	endfunction

	function automatic row_t load_row(beacon_id_t id, dbm_t pwr, logic eos);
		row_t r = '0;
		r.kind = ROW_ITEM;
		r.it   = '{func: FUNC_LOAD, id: id, rssi: '0, ref_pwr: pwr, eos: eos};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [KEEP_W-1:0] keep, dbm_t cutoff, logic adj);
		row_t r = '0;
		r.kind   = ROW_CFG;
		r.keep   = keep;
		r.cutoff = cutoff;
		r.adj    = adj;
		return r;
	endfunction

	function automatic row_t typed_row(row_t r, res_t want);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic beacon_id_t pick_id();
		int r = $urandom_range(0, 9);
		if (r < 8)
			return id_pool[$urandom_range(0, id_pool.size() - 1)];
		return $urandom;
	endfunction

	// writes all three registers, one per cycle
	task automatic write_config(input logic [KEEP_W-1:0] keep, input dbm_t cutoff,
			input logic adj);
		cfg_we    <= 1'b1;
		cfg_index <= REG_KEEP_COUNT;
		cfg_wdata <= CFG_DATA_W'(keep);
		@(posedge clk);
		cfg_index <= REG_CUTOFF_DBM;
		cfg_wdata <= cutoff;
		@(posedge clk);
		cfg_index <= REG_ADJUST_ENABLE;
		cfg_wdata <= CFG_DATA_W'(adj);
		@(posedge clk);
		cfg_we   <= 1'b0;
		m_keep   = keep;
		m_cutoff = cutoff;
		m_adj    = adj;
	endtask

	// drop valid, drain results, then give a trailing load time to finish
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one input transfer; expectations are queued at the accepting edge
	task automatic offer(input item_t it, input logic typed, input res_t want);
		int   gap;
		res_t exp_q [$];
		gap = tx_calm ? 0 : draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.func          <= it.func;
		in_ch.beacon_id     <= it.id;
		in_ch.signal_dbm    <= it.rssi;
		in_ch.ref_power_dbm <= it.ref_pwr;
		in_ch.end_of_scan   <= it.eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		rank_and_emit(it, exp_q);
		if (typed)
			pending_results = {pending_results, want};
		else
			foreach (exp_q[i])
				pending_results = {pending_results, exp_q[i]};
		if (it.func == FUNC_LOAD) begin
			n_loads++;
		end else begin
			n_beacons++;
			if (it.eos)
				n_scans++;
		end
	endtask

	// stimulus: directed table, then random phases
	initial begin : stimulus
		row_t              plan [$];
		item_t             it;
		int                scan_len;
		int                phase;
		int                rand_items;
		logic [KEEP_W-1:0] keep;
		dbm_t              cutoff;
		logic              adj;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.func          = FUNC_BEACON;
		in_ch.beacon_id     = '0;
		in_ch.signal_dbm    = '0;
		in_ch.ref_power_dbm = '0;
		in_ch.end_of_scan   = 1'b0;
		tx_calm             = 1'b0;
		repeat (12) id_pool = {id_pool, beacon_id_t'($urandom)};

		plan = '{
			// defaults after reset, id extremes, cutoff boundary
			typed_row(beacon_row(32'h0000_0000, 8'sd0, 1'b1),
				'{id: 32'h0, dbm: 8'sd0, vres: 1'b1, last: 1'b1}),
			typed_row(beacon_row(32'hFFFF_FFFF, -8'sd100, 1'b1), NO_SURVIVOR),
			typed_row(beacon_row(32'hFFFF_FFFF, -8'sd99, 1'b1),
				'{id: 32'hFFFF_FFFF, dbm: -8'sd99, vres: 1'b1, last: 1'b1}),
			// RSSI extremes and a tie on key
			beacon_row(ID_A, DBM_MIN, 1'b0),
			beacon_row(ID_B, DBM_MAX, 1'b0),
			beacon_row(ID_C, -8'sd50, 1'b0),
			beacon_row(ID_D, -8'sd50, 1'b1),
			// new id, overwrite of a known id, end flag on a load
			load_row(ID_A, DBM_MAX, 1'b0),
			load_row(ID_A, DBM_MIN, 1'b0),
			load_row(ID_B, 8'sd0, 1'b1),
			// adjusted keys mixed with an id missing from the table
			cfg_row(5'd10, -8'sd100, 1'b1),
			beacon_row(ID_A, -8'sd60, 1'b0),
			beacon_row(ID_B, -8'sd10, 1'b0),
			beacon_row(ID_E, -8'sd20, 1'b1),
			// nothing kept
			cfg_row(5'd0, -8'sd100, 1'b1),
			typed_row(beacon_row(ID_E, -8'sd30, 1'b1), NO_SURVIVOR),
			// keep count lowered in the middle of a scan
			cfg_row(5'd3, -8'sd100, 1'b0),
			beacon_row(ID_F, -8'sd40, 1'b0),
			beacon_row(ID_G, -8'sd45, 1'b0),
			beacon_row(ID_H, -8'sd35, 1'b0),
			beacon_row(ID_I, -8'sd50, 1'b0),
			cfg_row(5'd1, -8'sd100, 1'b0),
			beacon_row(ID_J, -8'sd90, 1'b1),
			// keep count saturates, highest cutoff lets nothing through
			cfg_row(5'd31, DBM_MAX, 1'b0),
			typed_row(beacon_row(ID_B, DBM_MAX, 1'b1), NO_SURVIVOR),
			// lowest cutoff, adjusted key of the lowest table power
			cfg_row(5'd16, DBM_MIN, 1'b1),
			beacon_row(ID_A, DBM_MIN, 1'b0),
			beacon_row(ID_C, -8'sd127, 1'b1)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_config(plan[i].keep, plan[i].cutoff, plan[i].adj);
			end else begin
				offer(plan[i].it, plan[i].typed, plan[i].want);
			end
		end

		// random phases: new settings, then a few scans with loads mixed in
		phase      = 0;
		rand_items = 0;
		while (phase < 2 || rand_items < RAND_ITEMS) begin
			settle();
			case ($urandom_range(0, 7))
				0: keep = '0;
				1: keep = 5'd1;
				2: keep = KEEP_W'(MAX_KEEP);
				3: keep = '1;
				default: keep = KEEP_W'($urandom_range(2, 15));
			endcase
			case ($urandom_range(0, 9))
				0: cutoff = DBM_MIN;
				1: cutoff = DBM_MAX;
				2: cutoff = dbm_t'($urandom);
				default: cutoff = dbm_t'(-int'($urandom_range(60, 100)));
			endcase
			adj = (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			write_config(keep, cutoff, adj);
			tx_calm = ($urandom_range(0, 3) == 0);

			// fill the table past its depth so that new ids are dropped
			if (phase == 1) begin
				repeat (FILL_LOADS) begin
					it.func    = FUNC_LOAD;
					it.id      = $urandom;
					it.rssi    = dbm_t'($urandom);
					it.ref_pwr = dbm_t'($urandom);
					it.eos     = 1'($urandom);
					id_pool    = {id_pool, it.id};
					offer(it, 1'b0, NO_SURVIVOR);
					rand_items++;
				end
			end

			repeat ($urandom_range(2, 4)) begin
				scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) :
					$urandom_range(1, 8);
				for (int b = 0; b < scan_len; b++) begin
					if ($urandom_range(0, 4) == 0) begin
						it.func    = FUNC_LOAD;
						it.id      = pick_id();
						it.rssi    = dbm_t'($urandom);
						it.ref_pwr = dbm_t'($urandom);
						it.eos     = 1'($urandom);
						offer(it, 1'b0, NO_SURVIVOR);
						rand_items++;
					end
					it.func    = FUNC_BEACON;
					it.id      = pick_id();
					it.rssi    = ($urandom_range(0, 6) == 0) ? dbm_t'($urandom) :
						dbm_t'(-int'($urandom_range(30, 100)));
					it.ref_pwr = dbm_t'($urandom);
					it.eos     = (b == scan_len - 1);
					offer(it, 1'b0, NO_SURVIVOR);
					rand_items++;
				end
			end
			phase++;
		end

		settle();
		$display("tb: %0d items (%0d loads, %0d beacons in %0d scans), %0d results, %0d mismatches",
			n_loads + n_beacons, n_loads, n_beacons, n_scans, results_seen, mismatches);
		$display("tb: table held %0d of %0d ids at the end, receiver held off %0d times",
			ref_fill, TABLE_DEPTH, holdoffs);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: check each transfer, then pick the next ready value
	initial begin : result_sink
		int   hold;
		int   calm_left;
		logic calm;
		res_t got;
		res_t want;
		hold         = 0;
		calm_left    = 0;
		calm         = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got = '{id: out_ch.out_id, dbm: out_ch.out_dbm, vres: out_ch.valid_res,
					last: out_ch.last};
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: unexpected result id=%h dbm=%0d valid_res=%b last=%b",
							got.id, got.dbm, got.vres, got.last);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"tb: result %0d expected id=%h dbm=%0d valid_res=%b last=%b,",
								" got id=%h dbm=%0d valid_res=%b last=%b"}, results_seen,
								want.id, want.dbm, want.vres, want.last,
								got.id, got.dbm, got.vres, got.last);
					end
				end
			end

			// windows with no stalls at all
			if (calm_left == 0) begin
				calm      = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(50, 300);
			end else begin
				calm_left--;
			end

			// long hold-off while the sender keeps offering, so the block backs up
			if (hold == 0 && holdoffs < 2 && results_seen >= 10 + 60 * holdoffs &&
					in_ch.valid && out_ch.valid) begin
				hold = HOLDOFF_CYCLES;
				holdoffs++;
			end else if (hold == 0 && !calm) begin
				hold = draw_gap();
			end

			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: no transfer for %0d cycles, %0d results still due", WATCHDOG_LIMIT,
			pending_results.size());
		$display("tb: failure");
		$finish;
	end

endmodule
